// ----- hdl/ddt_pkg.sv -----
// Shared types, constants and calendar helpers for the decimal date/time unit.
package ddt_pkg;

	localparam int unsigned DATE_W  = 27;
	localparam int unsigned TIME_W  = 18;
	localparam int unsigned ODATE_W = 28;
	localparam int unsigned DAY_W   = 20;
	localparam int unsigned YEAR_W  = 15;
	localparam int unsigned SEC_W   = 19;
	localparam int unsigned DIVR_W  = 14;
	localparam int unsigned RECIP_W = 22;

	localparam logic [DIVR_W-1:0] DIV_YEAR = 14'd10000;
	localparam logic [DIVR_W-1:0] DIV_CENT = 14'd100;
	localparam logic [DIVR_W-1:0] DIV_HOUR = 14'd3600;
	localparam logic [DIVR_W-1:0] DIV_MIN  = 14'd60;

	// floor(2^27 / divisor); a dividend below 2^27 leaves the estimate short by at most one
	localparam int unsigned       RECIP_SH   = 27;
	localparam logic [RECIP_W-1:0] RECIP_YEAR = 22'd13421;
	localparam logic [RECIP_W-1:0] RECIP_CENT = 22'd1342177;
	localparam logic [RECIP_W-1:0] RECIP_HOUR = 22'd37282;
	localparam logic [RECIP_W-1:0] RECIP_MIN  = 22'd2236962;

	localparam logic signed [SEC_W-1:0] DAY_SECONDS = 19'sd86400;
	localparam logic [YEAR_W-1:0] CENTURY_20 = 15'd2000;
	localparam logic [YEAR_W-1:0] CENTURY_19 = 15'd1900;

	// divider jobs, in the order the controller runs them
	typedef enum logic [3:0] {
		J_D1_YEAR,
		J_D1_MD,
		J_D2_YEAR,
		J_D2_MD,
		J_T1_H,
		J_T1_MS,
		J_T2_H,
		J_T2_MS,
		J_S_H,
		J_S_MS
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_PREP1,
		S_PREP2,
		S_WRAP,
		S_COMB1,
		S_COMB2,
		S_COMPOSE,
		S_FINISH,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_capture;
		job_t job;
		logic prep1;
		logic prep2;
		logic wrap;
		logic comb1;
		logic comb2;
		logic compose_step;
		logic finish;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic compose_more;
		logic out_free;
	} dp_status_t;

	// length of one month, zero outside 1..12
	function automatic logic [8:0] month_len(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 9'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 9'd30;
			4'd2: r = 9'd28;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// days in the months before month m, all twelve counted for m above 12
	function automatic logic [8:0] days_before(input logic [6:0] m);
		logic [8:0] r;
		case (m) inside
			7'd0, 7'd1: r = 9'd0;
			7'd2:  r = 9'd31;
			7'd3:  r = 9'd59;
			7'd4:  r = 9'd90;
			7'd5:  r = 9'd120;
			7'd6:  r = 9'd151;
			7'd7:  r = 9'd181;
			7'd8:  r = 9'd212;
			7'd9:  r = 9'd243;
			7'd10: r = 9'd273;
			7'd11: r = 9'd304;
			7'd12: r = 9'd334;
			default: r = 9'd365;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'd0) ? 9'd366 : 9'd365;
	endfunction

	// two-digit years move into the 1900s or 2000s
	function automatic logic [YEAR_W-1:0] widen(input logic [13:0] y);
		logic [YEAR_W-1:0] r;
		r = YEAR_W'(y);
		if (y != 14'd0 && y < 14'd50)
			r = YEAR_W'(y) + CENTURY_20;
		else if (y >= 14'd50 && y < 14'd100)
			r = YEAR_W'(y) + CENTURY_19;
		return r;
	endfunction

	function automatic logic [16:0] to_seconds(input logic [4:0] h, input logic [6:0] mi,
			input logic [6:0] sc);
		return 17'(h) * 17'd3600 + 17'(mi) * 17'd60 + 17'(sc);
	endfunction

endpackage

// ----- hdl/decimal_date_time_add_sub_unit.sv -----
// Top level of the decimal date/time add and subtract unit.
// Usage:
//   The slave channel takes one request: tuser is the operation (0 add,
//   1 subtract second from first), tdata holds first_date, first_time,
//   second_date and second_time. The master channel returns one result:
//   tdata holds result_date (signed) and result_time, tuser flags an
//   attempt to add two absolute dates (date and time then read zero).
//   One request is worked at a time. Each request runs ten divisions by a
//   constant through one shared divider (reciprocal multiply and one
//   correction) and day arithmetic, then month search and result load before
//   m_tvalid rises. The ten divisions and the month search set the
//   throughput: no new request is taken while one is being worked.
//   A new request is taken as soon as the previous one has reached the
//   result register, even while that result still waits to be taken.
//   If the receiver stalls, the finished result is held in the register
//   and the next computation waits before loading its own.
//   Reset clears the controller and the result valid flag; no result is
//   pending after reset.
module decimal_date_time_add_sub_unit
	import ddt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // first_date, first_time, second_date, second_time
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_date, result_time
	output logic        m_tuser   // absolute_pair_error
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ddt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ddt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten");

	// after a request is taken the unit is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// an error result carries zero date and time
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 48'd0)
		else $error("error result with nonzero data");

endmodule

// ----- hdl/ddt_div.sv -----
// Constant divider: reciprocal multiply, then one compare and subtract; the controller gives it one job at a time.
module ddt_div
	import ddt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATE_W-1:0] dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic              done,
	output logic [DATE_W-1:0] quot,
	output logic [DIVR_W-1:0] rem
);

	logic                      v1_q, v2_q, done_q;
	logic [DATE_W-1:0]         dvd_s1, dvd_s2, q0_s2;
	logic [DIVR_W-1:0]         dsr_s1, dsr_s2;
	logic [RECIP_W-1:0]        rcp_s1;
	logic [DATE_W-1:0]         quot_q;
	logic [DIVR_W-1:0]         rem_q;
	logic [RECIP_W-1:0]        recip;
	logic [DATE_W+RECIP_W-1:0] prod;
	logic [DIVR_W:0]           r0;
	logic                      fix;

	// reciprocal of the job's divisor
	always_comb begin
		case (divisor)
			DIV_YEAR: recip = RECIP_YEAR;
			DIV_CENT: recip = RECIP_CENT;
			DIV_HOUR: recip = RECIP_HOUR;
			DIV_MIN:  recip = RECIP_MIN;
			default:  recip = RECIP_YEAR;
		endcase
	end

	// quotient estimate
	assign prod = (DATE_W+RECIP_W)'(dvd_s1) * (DATE_W+RECIP_W)'(rcp_s1);

	// the estimate is short by at most one: compare and subtract once
	assign r0  = (DIVR_W+1)'(dvd_s2 - q0_s2 * DATE_W'(dsr_s2));
	assign fix = r0 >= {1'b0, dsr_s2};

	// stage valids and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_q   <= start;
			v2_q   <= v1_q;
			done_q <= v2_q;
		end
	end

	// operand, estimate and result registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1 <= dividend;
			dsr_s1 <= divisor;
			rcp_s1 <= recip;
		end
		if (v1_q) begin
			dvd_s2 <= dvd_s1;
			dsr_s2 <= dsr_s1;
			q0_s2  <= DATE_W'(prod >> RECIP_SH);
		end
		if (v2_q) begin
			quot_q <= q0_s2 + DATE_W'(fix);
			rem_q  <= fix ? DIVR_W'(r0 - {1'b0, dsr_s2}) : r0[DIVR_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/ddt_datapath.sv -----
// Datapath: operand split, day and second arithmetic, date rebuild, result register.
module ddt_datapath
	import ddt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tuser
);

	logic              op_q;
	logic [DATE_W-1:0] d1_q, d2_q;
	logic [TIME_W-1:0] t1_q, t2_q;
	logic [13:0]       y1_q, y2_q, r1_q, r2_q, tr1_q, tr2_q;
	logic [6:0]        mo1_q, mo2_q, dd1_q, dd2_q, mi1_q, mi2_q, sc1_q, sc2_q;
	logic [4:0]        h1_q, h2_q, hh_q;
	logic [11:0]       sr_q;
	logic [5:0]        mm_q, ss_q;
	logic [YEAR_W-1:0] yw1_q, yw2_q, year_q;
	logic              abs1_q, abs2_q, err_q;
	logic [16:0]       sec1_q, sec2_q;
	logic signed [DAY_W-1:0] day1_q, day2_q, dn_q;
	logic signed [SEC_W-1:0] s_q;
	logic [3:0]        mon_q;
	logic              out_valid_q;
	logic [ODATE_W-1:0] out_date_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_err_q;

	logic              div_done;
	logic [DATE_W-1:0] div_quot;
	logic [DIVR_W-1:0] div_rem;
	logic [DATE_W-1:0] div_dvd;
	logic [DIVR_W-1:0] div_dsr;

	logic [8:0]        cur_len, prev_len, yl_year, yl_prev, yl_1, yl_2;
	logic [YEAR_W-1:0] year_prev;
	logic [3:0]        mon_prev;
	logic [28:0]       year_part;
	logic [10:0]       mon_part;
	logic signed [29:0] date_full;
	logic [TIME_W-1:0] hms;
	logic signed [DAY_W-1:0] cur_len_s;

	// pick dividend and divisor for the running job
	always_comb begin
		div_dvd = '0;
		div_dsr = DIV_YEAR;
		case (cmd.job)
			J_D1_YEAR: begin div_dvd = d1_q; div_dsr = DIV_YEAR; end
			J_D1_MD:   begin div_dvd = DATE_W'(r1_q); div_dsr = DIV_CENT; end
			J_D2_YEAR: begin div_dvd = d2_q; div_dsr = DIV_YEAR; end
			J_D2_MD:   begin div_dvd = DATE_W'(r2_q); div_dsr = DIV_CENT; end
			J_T1_H:    begin div_dvd = DATE_W'(t1_q); div_dsr = DIV_YEAR; end
			J_T1_MS:   begin div_dvd = DATE_W'(tr1_q); div_dsr = DIV_CENT; end
			J_T2_H:    begin div_dvd = DATE_W'(t2_q); div_dsr = DIV_YEAR; end
			J_T2_MS:   begin div_dvd = DATE_W'(tr2_q); div_dsr = DIV_CENT; end
			J_S_H:     begin div_dvd = DATE_W'(unsigned'(s_q)); div_dsr = DIV_HOUR; end
			J_S_MS:    begin div_dvd = DATE_W'(sr_q); div_dsr = DIV_MIN; end
			default:   begin div_dvd = '0; div_dsr = DIV_YEAR; end
		endcase
	end

	ddt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// month and year helpers
	assign cur_len   = month_len(mon_q);
	assign cur_len_s = $signed({11'd0, cur_len});
	assign mon_prev  = mon_q - 4'd1;
	assign prev_len  = month_len(mon_prev);
	assign year_prev = year_q - 15'd1;
	assign yl_year   = year_len(year_q);
	assign yl_prev   = year_len(year_prev);
	assign yl_1      = year_len(yw1_q);
	assign yl_2      = year_len(yw2_q);

	// rebuild decimal date and time
	assign year_part = 29'(year_q) * 29'(DIV_YEAR);
	assign mon_part  = 11'(mon_q) * 11'd100;
	assign date_full = $signed({1'b0, year_part}) + $signed({19'd0, mon_part}) + 30'(dn_q);
	assign hms = 18'(hh_q) * 18'd10000 + 18'(mm_q) * 18'd100 + 18'(ss_q);

	// operand registers and arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= s_tuser;
			d1_q <= s_tdata[26:0];
			t1_q <= s_tdata[44:27];
			d2_q <= s_tdata[71:45];
			t2_q <= s_tdata[89:72];
		end
		if (cmd.div_capture) begin
			case (cmd.job)
				J_D1_YEAR: begin y1_q <= div_quot[13:0]; r1_q <= div_rem; end
				J_D1_MD:   begin mo1_q <= div_quot[6:0]; dd1_q <= div_rem[6:0]; end
				J_D2_YEAR: begin y2_q <= div_quot[13:0]; r2_q <= div_rem; end
				J_D2_MD:   begin mo2_q <= div_quot[6:0]; dd2_q <= div_rem[6:0]; end
				J_T1_H:    begin h1_q <= div_quot[4:0]; tr1_q <= div_rem; end
				J_T1_MS:   begin mi1_q <= div_quot[6:0]; sc1_q <= div_rem[6:0]; end
				J_T2_H:    begin h2_q <= div_quot[4:0]; tr2_q <= div_rem; end
				J_T2_MS:   begin mi2_q <= div_quot[6:0]; sc2_q <= div_rem[6:0]; end
				J_S_H:     begin hh_q <= div_quot[4:0]; sr_q <= div_rem[11:0]; end
				J_S_MS:    begin mm_q <= div_quot[5:0]; ss_q <= div_rem[5:0]; end
				default:   begin end
			endcase
		end
		// widen years, day of year, seconds of day
		if (cmd.prep1) begin
			yw1_q  <= widen(y1_q);
			yw2_q  <= widen(y2_q);
			abs1_q <= y1_q != 14'd0;
			abs2_q <= y2_q != 14'd0;
			if (y1_q != 14'd0)
				day1_q <= DAY_W'(days_before(mo1_q)) + DAY_W'(dd1_q)
					+ DAY_W'(y1_q[1:0] == 2'd0 && mo1_q > 7'd2);
			else
				day1_q <= DAY_W'(r1_q);
			if (y2_q != 14'd0)
				day2_q <= DAY_W'(days_before(mo2_q)) + DAY_W'(dd2_q)
					+ DAY_W'(y2_q[1:0] == 2'd0 && mo2_q > 7'd2);
			else
				day2_q <= DAY_W'(r2_q);
			sec1_q <= to_seconds(h1_q, mi1_q, sc1_q);
			sec2_q <= to_seconds(h2_q, mi2_q, sc2_q);
		end
		// choose working year, credit one year between two absolute dates
		if (cmd.prep2) begin
			err_q <= !op_q && abs1_q && abs2_q;
			if (!op_q) begin
				year_q <= abs1_q ? yw1_q : yw2_q;
				s_q    <= $signed({2'd0, sec1_q}) + $signed({2'd0, sec2_q});
			end else begin
				s_q <= $signed({2'd0, sec1_q}) - $signed({2'd0, sec2_q});
				if (!abs1_q) begin
					year_q <= yw2_q;
				end else if (abs2_q) begin
					year_q <= '0;
					if (yw1_q > yw2_q)
						day1_q <= day1_q + $signed({11'd0, yl_2});
					else if (yw2_q > yw1_q)
						day2_q <= day2_q + $signed({11'd0, yl_1});
				end else begin
					year_q <= yw1_q;
				end
			end
		end
		// carry or borrow one day of seconds
		if (cmd.wrap) begin
			if (s_q >= DAY_SECONDS) begin
				day1_q <= day1_q + 20'sd1;
				s_q    <= s_q - DAY_SECONDS;
			end else if (s_q < 19'sd0) begin
				day1_q <= day1_q - 20'sd1;
				s_q    <= s_q + DAY_SECONDS;
			end
		end
		if (cmd.comb1)
			day1_q <= op_q ? day1_q - day2_q : day1_q + day2_q;
		// one year wrap, then start month search
		if (cmd.comb2) begin
			mon_q <= 4'd1;
			dn_q  <= day1_q;
			if (year_q != '0) begin
				if (!op_q && day1_q > $signed({11'd0, yl_year})) begin
					year_q <= year_q + 15'd1;
					day1_q <= day1_q - $signed({11'd0, yl_year});
					dn_q   <= day1_q - $signed({11'd0, yl_year});
				end else if (op_q && day1_q <= 20'sd0) begin
					year_q <= year_prev;
					day1_q <= day1_q + $signed({11'd0, yl_prev});
					dn_q   <= day1_q + $signed({11'd0, yl_prev});
				end
			end
		end
		if (cmd.compose_step) begin
			dn_q  <= dn_q - cur_len_s;
			mon_q <= mon_q + 4'd1;
		end
		// leap day correction
		if (cmd.finish && year_q[1:0] == 2'd0 && mon_q > 4'd2) begin
			if (dn_q == 20'sd1) begin
				mon_q <= mon_prev;
				dn_q  <= (mon_prev == 4'd2) ? 20'sd29 : $signed({11'd0, prev_len});
			end else begin
				dn_q <= dn_q - 20'sd1;
			end
		end
		if (cmd.out_load) begin
			out_err_q <= err_q;
			if (err_q) begin
				out_date_q <= '0;
				out_time_q <= '0;
			end else begin
				out_time_q <= hms;
				out_date_q <= (year_q == '0) ? ODATE_W'(day1_q) : date_full[ODATE_W-1:0];
			end
		end
	end

	// result valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign status.div_done     = div_done;
	assign status.compose_more = (mon_q <= 4'd12) && (dn_q > cur_len_s);
	assign status.out_free     = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_time_q, out_date_q};
	assign m_tuser  = out_err_q;

endmodule

// ----- hdl/ddt_ctrl.sv -----
// Controller: sequences divider jobs and arithmetic steps for one request.
module ddt_ctrl
	import ddt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_n;
	job_t        job_q, job_n;
	logic        wrap_q, wrap_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_D1_YEAR;
			wrap_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			job_q   <= job_n;
			wrap_q  <= wrap_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		job_n    = job_q;
		wrap_n   = wrap_q;
		cmd      = '0;
		cmd.job  = job_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					job_n    = J_D1_YEAR;
					state_n  = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_n       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					if (job_q == J_T2_MS) begin
						state_n = S_PREP1;
					end else if (job_q == J_S_MS) begin
						state_n = S_COMB1;
					end else begin
						job_n   = job_t'(job_q + 4'd1);
						state_n = S_DIV_GO;
					end
				end
			end
			S_PREP1: begin
				cmd.prep1 = 1'b1;
				state_n   = S_PREP2;
			end
			S_PREP2: begin
				cmd.prep2 = 1'b1;
				wrap_n    = 1'b0;
				state_n   = S_WRAP;
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				if (wrap_q) begin
					job_n   = J_S_H;
					state_n = S_DIV_GO;
				end else begin
					wrap_n = 1'b1;
				end
			end
			S_COMB1: begin
				cmd.comb1 = 1'b1;
				state_n   = S_COMB2;
			end
			S_COMB2: begin
				cmd.comb2 = 1'b1;
				state_n   = S_COMPOSE;
			end
			S_COMPOSE: begin
				if (status.compose_more)
					cmd.compose_step = 1'b1;
				else
					state_n = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_n    = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule
